// ===== hdl/sbs_pkg.sv =====
package sbs_pkg;

  // Packet and image geometry
  localparam int BLOCK_BYTES     = 64;
  localparam int BLOCK_SHIFT     = 6;
  localparam int IMAGE_BYTES_DEF = 4096;

  // Acknowledgement marks and sender identity
  localparam logic [15:0] END_MARK     = 16'hFFFF;
  localparam logic [15:0] RESTART_MARK = 16'hFFFE;
  localparam logic [15:0] SENDER_ID    = 16'd2;
  localparam logic [6:0]  END_LEN      = 7'd4;

  // CRC-32, reflected
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_ACK   = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Configuration register indexes
  localparam int          CFG_IDX_W    = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LEN = 2'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        route_ready;
    logic [15:0] ack_number;
    logic        ack_size_ok;
    logic [11:0] image_address;
    logic [7:0]  image_byte;
  } sbs_req_t;

  typedef struct packed {
    logic [15:0] block_number;
    logic [6:0]  data_length;
    logic [15:0] block_checksum;
    logic [5:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        last_byte;
  } sbs_res_t;

  // Datapath operations of one control word
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_FILL_INIT,
    UOP_FILL_PRIME,
    UOP_FILL_STEP,
    UOP_CRC_INIT,
    UOP_CRC_STEP,
    UOP_CRC_FIN,
    UOP_CRC_WR,
    UOP_EMIT_PRIME,
    UOP_EMIT_STEP
  } uop_e;

  // Jump conditions
  typedef enum logic [3:0] {
    UC_NEVER,
    UC_ALWAYS,
    UC_ALL_ACKED,
    UC_RESEND,
    UC_LEN_ZERO,
    UC_FILL_MORE,
    UC_CRC_MORE,
    UC_WR_MORE,
    UC_EMIT_MORE
  } ucond_e;

  localparam int PC_W = 4;

  typedef struct packed {
    uop_e            op;
    ucond_e          cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Program step addresses
  localparam logic [PC_W-1:0] STEP_IDLE       = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHECK      = 4'd1;
  localparam logic [PC_W-1:0] STEP_CHECK_ACK  = 4'd2;
  localparam logic [PC_W-1:0] STEP_FILL_INIT  = 4'd3;
  localparam logic [PC_W-1:0] STEP_FILL_PRIME = 4'd4;
  localparam logic [PC_W-1:0] STEP_FILL_LOOP  = 4'd5;
  localparam logic [PC_W-1:0] STEP_FILL_EXIT  = 4'd6;
  localparam logic [PC_W-1:0] STEP_CRC_INIT   = 4'd7;
  localparam logic [PC_W-1:0] STEP_CRC_LOOP   = 4'd8;
  localparam logic [PC_W-1:0] STEP_CRC_FIN    = 4'd9;
  localparam logic [PC_W-1:0] STEP_CRC_WR     = 4'd10;
  localparam logic [PC_W-1:0] STEP_EMIT_PRIME = 4'd11;
  localparam logic [PC_W-1:0] STEP_EMIT_LOOP  = 4'd12;
  localparam logic [PC_W-1:0] STEP_EMIT_EXIT  = 4'd13;

  // Control store: one word per step
  function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: UOP_NOP, cond: UC_ALWAYS, target: STEP_IDLE};
    case (pc)
      STEP_IDLE:       w = '{UOP_NOP,        UC_ALWAYS,    STEP_IDLE};
      STEP_CHECK:      w = '{UOP_NOP,        UC_ALL_ACKED, STEP_CRC_INIT};
      STEP_CHECK_ACK:  w = '{UOP_NOP,        UC_RESEND,    STEP_EMIT_PRIME};
      STEP_FILL_INIT:  w = '{UOP_FILL_INIT,  UC_NEVER,     STEP_IDLE};
      STEP_FILL_PRIME: w = '{UOP_FILL_PRIME, UC_NEVER,     STEP_IDLE};
      STEP_FILL_LOOP:  w = '{UOP_FILL_STEP,  UC_FILL_MORE, STEP_FILL_LOOP};
      STEP_FILL_EXIT:  w = '{UOP_NOP,        UC_ALWAYS,    STEP_EMIT_PRIME};
      STEP_CRC_INIT:   w = '{UOP_CRC_INIT,   UC_LEN_ZERO,  STEP_CRC_FIN};
      STEP_CRC_LOOP:   w = '{UOP_CRC_STEP,   UC_CRC_MORE,  STEP_CRC_LOOP};
      STEP_CRC_FIN:    w = '{UOP_CRC_FIN,    UC_NEVER,     STEP_IDLE};
      STEP_CRC_WR:     w = '{UOP_CRC_WR,     UC_WR_MORE,   STEP_CRC_WR};
      STEP_EMIT_PRIME: w = '{UOP_EMIT_PRIME, UC_NEVER,     STEP_IDLE};
      STEP_EMIT_LOOP:  w = '{UOP_EMIT_STEP,  UC_EMIT_MORE, STEP_EMIT_LOOP};
      STEP_EMIT_EXIT:  w = '{UOP_NOP,        UC_ALWAYS,    STEP_IDLE};
      default:         w = '{UOP_NOP,        UC_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

  // Fold one byte into a reflected CRC-32
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/sbs_ram.sv =====
module sbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/stop_and_wait_block_sender_top.sv =====
// Stop-and-wait block sender.
// Command channel: an item is taken when start_i is high and busy_o is low.
// Image writes and acknowledgements complete in the cycle they are taken and
// never raise busy_o. A send tick that is allowed (transfer not done, route
// ready, node identity 2) runs the control program and raises busy_o; other
// ticks are dropped.
// Each tick that sends produces 64 results, one per packet byte, on res_o
// with res_valid_o high for one cycle each, in consecutive cycles; the last
// one carries last_byte. The receiver cannot stall: every strobe is a transfer.
// How a sending tick makes its packet:
//   resent block: the held packet RAM is read out as it stands;
//   fresh block: image bytes are copied into the held packet RAM and
//     summed, one image byte per cycle, then the packet is read out;
//   end packet: a byte-serial CRC reads one image byte per cycle from the
//     image RAM, its four bytes go into the held packet RAM, then readout.
// busy_o falls at the edge that takes the last result; the next command can
// be taken from then on. Configuration writes are always ready, act at once.
// Reset clears the block counter, the done flag and the node identity, sets
// the acknowledge flag and an image length of 4096; the payload registers
// and the image RAM hold no defined data until written.
module stop_and_wait_block_sender_top import sbs_pkg::*; #(
  parameter int IMAGE_BYTES = IMAGE_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  sbs_req_t             req_i,
  output logic                 res_valid_o,
  output sbs_res_t             res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  localparam int AW = $clog2(IMAGE_BYTES);
  localparam int CW = $clog2(IMAGE_BYTES + 1);
  localparam int HW = BLOCK_SHIFT;
  localparam int OW = 16 + BLOCK_SHIFT;

  // Control state
  logic [PC_W-1:0] pc_q, pc_d;
  logic [15:0]     next_block_q, next_block_d;
  logic            ack_seen_q, ack_seen_d;
  logic            done_q, done_d;
  logic [15:0]     node_id_q, node_id_d;
  logic [12:0]     img_len_q, img_len_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            res_valid_q, res_valid_d;

  // Datapath payload
  logic [15:0]     held_block_q, held_block_d;
  logic [6:0]      held_len_q, held_len_d;
  logic [15:0]     held_sum_q, held_sum_d;
  logic [31:0]     crc_q, crc_d;
  logic [AW-1:0]   offset_q, offset_d;
  sbs_res_t        res_q, res_d;

  // RAM ports
  logic            img_we;
  logic [AW-1:0]   img_waddr;
  logic [AW-1:0]   img_raddr;
  logic [7:0]      img_rdata;
  logic            held_we;
  logic [HW-1:0]   held_waddr;
  logic [7:0]      held_wdata;
  logic [HW-1:0]   held_raddr;
  logic [7:0]      held_rdata;

  uword_t          uw;
  logic            accept;
  logic            tick_ok;
  logic            cond_hit;
  logic [CW-1:0]   eff_len;
  logic [OW-1:0]   block_base;
  logic [OW-1:0]   remain;
  logic [CW-1:0]   cnt_prev;
  logic [6:0]      emit_idx;

  sbs_ram #(.WIDTH(8), .DEPTH(IMAGE_BYTES)) u_image_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i (req_i.image_byte),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  sbs_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (held_we),
    .waddr_i (held_waddr),
    .wdata_i (held_wdata),
    .raddr_i (held_raddr),
    .rdata_o (held_rdata)
  );

  assign busy_o      = (pc_q != STEP_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign uw          = ucode_rom(pc_q);

  // Clamp the image length to the store
  always_comb begin
    if (32'(img_len_q) > 32'(IMAGE_BYTES)) begin
      eff_len = CW'(IMAGE_BYTES);
    end else begin
      eff_len = CW'(img_len_q);
    end
  end

  assign block_base = {next_block_q, {BLOCK_SHIFT{1'b0}}};
  assign remain     = OW'(eff_len) - block_base;
  assign cnt_prev   = cnt_q - CW'(1);
  assign emit_idx   = 7'(cnt_prev);
  assign tick_ok    = (req_i.req_type == REQ_TICK) && !done_q && req_i.route_ready &&
                      (node_id_q == SENDER_ID);

  // Evaluate the jump condition of the current step
  always_comb begin
    case (uw.cond)
      UC_NEVER:     cond_hit = 1'b0;
      UC_ALWAYS:    cond_hit = 1'b1;
      UC_ALL_ACKED: cond_hit = (block_base >= OW'(eff_len));
      UC_RESEND:    cond_hit = !ack_seen_q;
      UC_LEN_ZERO:  cond_hit = (eff_len == '0);
      UC_FILL_MORE: cond_hit = (cnt_q != CW'(held_len_q));
      UC_CRC_MORE:  cond_hit = (cnt_q != eff_len);
      UC_WR_MORE:   cond_hit = (cnt_q[1:0] != 2'd3);
      UC_EMIT_MORE: cond_hit = (cnt_q != CW'(BLOCK_BYTES));
      default:      cond_hit = 1'b0;
    endcase
  end

  // Sequencer and datapath next state
  always_comb begin
    pc_d         = cond_hit ? uw.target : pc_q + PC_W'(1);
    next_block_d = next_block_q;
    ack_seen_d   = ack_seen_q;
    done_d       = done_q;
    node_id_d    = node_id_q;
    img_len_d    = img_len_q;
    cnt_d        = cnt_q;
    res_valid_d  = 1'b0;
    held_block_d = held_block_q;
    held_len_d   = held_len_q;
    held_sum_d   = held_sum_q;
    crc_d        = crc_q;
    offset_d     = offset_q;
    res_d        = res_q;
    img_we       = 1'b0;
    img_waddr    = AW'(req_i.image_address);
    img_raddr    = AW'(cnt_q);
    held_we      = 1'b0;
    held_waddr   = HW'(cnt_prev);
    held_wdata   = img_rdata;
    held_raddr   = HW'(cnt_q);

    // Configuration writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NODE_ID:   node_id_d = cfg_data_i;
        CFG_IMAGE_LEN: img_len_d = cfg_data_i[12:0];
        default:       ;
      endcase
    end

    // Take a command while idle
    if (pc_q == STEP_IDLE) begin
      pc_d = STEP_IDLE;
      if (accept) begin
        case (req_i.req_type)
          REQ_TICK: begin
            if (tick_ok) begin
              pc_d = STEP_CHECK;
            end
          end
          REQ_ACK: begin
            if (req_i.ack_size_ok) begin
              if (req_i.ack_number == END_MARK) begin
                done_d     = 1'b1;
                ack_seen_d = 1'b1;
              end else if (req_i.ack_number == RESTART_MARK) begin
                next_block_d = '0;
                ack_seen_d   = 1'b1;
              end else if (req_i.ack_number == next_block_q) begin
                ack_seen_d   = 1'b1;
                next_block_d = next_block_q + 16'd1;
              end
            end
          end
          REQ_WRITE: begin
            img_we = (32'(req_i.image_address) < 32'(IMAGE_BYTES));
          end
          default: ;
        endcase
      end
    end

    // Datapath action of the current control word
    case (uw.op)
      UOP_FILL_INIT: begin
        offset_d     = AW'(block_base);
        held_block_d = next_block_q;
        held_len_d   = (remain < OW'(BLOCK_BYTES)) ? 7'(remain) : 7'(BLOCK_BYTES);
        held_sum_d   = '0;
        ack_seen_d   = 1'b0;
      end
      UOP_FILL_PRIME: begin
        img_raddr = offset_q;
        cnt_d     = CW'(1);
      end
      UOP_FILL_STEP: begin
        held_we    = 1'b1;
        held_sum_d = held_sum_q + {8'd0, img_rdata};
        img_raddr  = offset_q + AW'(cnt_q);
        cnt_d      = cnt_q + CW'(1);
      end
      UOP_CRC_INIT: begin
        crc_d     = CRC_INIT;
        img_raddr = '0;
        cnt_d     = CW'(1);
      end
      UOP_CRC_STEP: begin
        crc_d = crc_byte(crc_q, img_rdata);
        cnt_d = cnt_q + CW'(1);
      end
      UOP_CRC_FIN: begin
        crc_d        = crc_q ^ CRC_INIT;
        held_block_d = END_MARK;
        held_len_d   = END_LEN;
        held_sum_d   = '0;
        cnt_d        = '0;
      end
      UOP_CRC_WR: begin
        held_we    = 1'b1;
        held_waddr = HW'(cnt_q);
        held_wdata = 8'(crc_q >> {cnt_q[1:0], 3'b000});
        cnt_d      = cnt_q + CW'(1);
      end
      UOP_EMIT_PRIME: begin
        held_raddr = '0;
        cnt_d      = CW'(1);
      end
      UOP_EMIT_STEP: begin
        res_valid_d          = 1'b1;
        res_d.block_number   = held_block_q;
        res_d.data_length    = held_len_q;
        res_d.block_checksum = held_sum_q;
        res_d.byte_index     = 6'(cnt_prev);
        res_d.payload_byte   = (emit_idx < held_len_q) ? held_rdata : 8'd0;
        res_d.last_byte      = (cnt_q == CW'(BLOCK_BYTES));
        cnt_d                = cnt_q + CW'(1);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= STEP_IDLE;
      next_block_q <= '0;
      ack_seen_q   <= 1'b1;
      done_q       <= 1'b0;
      node_id_q    <= '0;
      img_len_q    <= 13'd4096;
      cnt_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      pc_q         <= pc_d;
      next_block_q <= next_block_d;
      ack_seen_q   <= ack_seen_d;
      done_q       <= done_d;
      node_id_q    <= node_id_d;
      img_len_q    <= img_len_d;
      cnt_q        <= cnt_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    held_block_q <= held_block_d;
    held_len_q   <= held_len_d;
    held_sum_q   <= held_sum_d;
    crc_q        <= crc_d;
    offset_q     <= offset_d;
    res_q        <= res_d;
  end

endmodule

// ===== hdl/sbs_checker.sv =====
module sbs_checker import sbs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     busy_o,
  input logic     res_valid_o,
  input sbs_res_t res_o
);

  // Results appear only while a tick is in progress or right after it
  a_res_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o))
    else $error("result strobe outside of a tick");

  // Last byte flag marks the final packet position
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.last_byte == (res_o.byte_index == 6'd63)))
    else $error("last_byte does not match byte_index");

  // Bytes of one packet come in consecutive cycles, in order
  a_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_byte |=>
      res_valid_o && (res_o.byte_index == $past(res_o.byte_index) + 6'd1))
    else $error("packet bytes not contiguous");

  // Bytes past the data length are zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && ({1'b0, res_o.byte_index} >= res_o.data_length) |->
      (res_o.payload_byte == 8'd0))
    else $error("nonzero padding byte");

endmodule

bind stop_and_wait_block_sender_top sbs_checker u_sbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ===== verif/tb.sv =====
module tb import sbs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Request code with no meaning; the block must drop it
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 80;
  // Image bytes written up front: one full block and a short second one
  localparam int PRELOAD_BYTES = 70;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  sbs_req_t             req_i;
  logic                 res_valid_o;
  sbs_res_t             res_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0]          cfg_data_i;

  // Sender state as the testbench sees it
  logic [7:0]  img_mem [IMAGE_BYTES_DEF];
  bit          img_wr  [IMAGE_BYTES_DEF];
  logic [15:0] blk_next;
  logic        blk_acked;
  logic        xfer_done;
  logic [15:0] node_id_reg;
  logic [12:0] img_len_reg;

  // Held packet, replayed on every resend
  logic [15:0] pkt_block;
  logic [6:0]  pkt_len;
  logic [15:0] pkt_sum;
  logic [7:0]  pkt_data [BLOCK_BYTES];

  sbs_res_t packet_bytes_q [$];
  int       errors;
  int       cycle_count;
  bit       steady_send;

  stop_and_wait_block_sender_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Apply one accepted request to the sender state and queue the packet bytes it sends
  function automatic void predict_request(sbs_req_t r);
    int          len, nblocks, base, dlen;
    logic [31:0] crc;
    sbs_res_t    b;
    len = (img_len_reg > IMAGE_BYTES_DEF) ? IMAGE_BYTES_DEF : int'(img_len_reg);
    case (r.req_type)
      REQ_TICK: if (!xfer_done && r.route_ready && node_id_reg == SENDER_ID) begin
        nblocks = (len + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (blk_next >= nblocks) begin
          // All blocks acknowledged: end packet with CRC-32, low byte first
          crc = CRC_INIT;
          for (int i = 0; i < len; i++) begin
            crc ^= {24'd0, img_mem[i]};
            for (int k = 0; k < 8; k++) crc = (crc >> 1) ^ (CRC_POLY & {32{crc[0]}});
          end
          crc ^= CRC_INIT;
          pkt_block = END_MARK;
          pkt_len   = END_LEN;
          pkt_sum   = '0;
          foreach (pkt_data[i]) pkt_data[i] = '0;
          for (int i = 0; i < 4; i++) pkt_data[i] = crc[8*i +: 8];
        end else if (blk_acked) begin
          // Build a fresh block; bytes past the data length stay zero
          base    = int'(blk_next) * BLOCK_BYTES;
          dlen    = (len - base < BLOCK_BYTES) ? len - base : BLOCK_BYTES;
          pkt_sum = '0;
          for (int i = 0; i < BLOCK_BYTES; i++) begin
            pkt_data[i] = 8'd0;
            if (i < dlen) pkt_data[i] = img_mem[base + i];
            pkt_sum = pkt_sum + {8'd0, pkt_data[i]};
          end
          pkt_block = blk_next;
          pkt_len   = 7'(dlen);
          blk_acked = 1'b0;
        end
        for (int i = 0; i < BLOCK_BYTES; i++) begin
          b.block_number   = pkt_block;
          b.data_length    = pkt_len;
          b.block_checksum = pkt_sum;
          b.byte_index     = 6'(i);
          b.payload_byte   = pkt_data[i];
          b.last_byte      = (i == BLOCK_BYTES - 1);
          packet_bytes_q.push_back(b);
        end
      end
      REQ_ACK: if (r.ack_size_ok) begin
        if (r.ack_number == END_MARK) begin
          xfer_done = 1'b1;
          blk_acked = 1'b1;
        end else if (r.ack_number == RESTART_MARK) begin
          blk_next  = '0;
          blk_acked = 1'b1;
        end else if (r.ack_number == blk_next) begin
          blk_acked = 1'b1;
          blk_next  = blk_next + 16'd1;
        end
      end
      REQ_WRITE: begin
        img_mem[r.image_address] = r.image_byte;
        img_wr[r.image_address]  = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // True when a sending tick now would read only image bytes already written
  function automatic bit tick_reads_written();
    int len, nblocks, base, dlen;
    bit ok;
    len     = (img_len_reg > IMAGE_BYTES_DEF) ? IMAGE_BYTES_DEF : int'(img_len_reg);
    nblocks = (len + BLOCK_BYTES - 1) / BLOCK_BYTES;
    ok      = 1'b1;
    if (blk_next >= nblocks) begin
      for (int i = 0; i < len; i++) if (!img_wr[i]) ok = 1'b0;
    end else if (blk_acked) begin
      base = int'(blk_next) * BLOCK_BYTES;
      dlen = (len - base < BLOCK_BYTES) ? len - base : BLOCK_BYTES;
      for (int i = 0; i < dlen; i++) if (!img_wr[base + i]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare every packet byte transfer with the oldest pending one
  always @(posedge clk_i) begin : check_bytes
    sbs_res_t want;
    if (rst_ni && res_valid_o !== 1'b0) begin
      if (packet_bytes_q.size() == 0) begin
        $display("%0t ns: unexpected packet byte, expected none, got %p", $time, res_o);
        errors++;
      end else begin
        want = packet_bytes_q.pop_front();
        check_field("block_number", want.block_number, res_o.block_number);
        check_field("data_length", 16'(want.data_length), 16'(res_o.data_length));
        check_field("block_checksum", want.block_checksum, res_o.block_checksum);
        check_field("byte_index", 16'(want.byte_index), 16'(res_o.byte_index));
        check_field("payload_byte", 16'(want.payload_byte), 16'(res_o.payload_byte));
        check_field("last_byte", 16'(want.last_byte), 16'(res_o.last_byte));
      end
    end
  end

  // Random content in every field, then fix the request code
  function automatic sbs_req_t noisy_req(logic [1:0] kind);
    sbs_req_t r;
    r.req_type      = kind;
    r.route_ready   = 1'($urandom);
    r.ack_number    = 16'($urandom);
    r.ack_size_ok   = 1'($urandom);
    r.image_address = 12'($urandom);
    r.image_byte    = 8'($urandom);
    return r;
  endfunction

  // Offer one request and hold it until the transfer
  task automatic send_item(sbs_req_t r);
    int gap;
    gap = (!steady_send && $urandom_range(99) < 13) ? $urandom_range(1, 3) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    req_i   = r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_request(r);
  endtask

  task automatic send_tick(logic route);
    sbs_req_t r;
    r = noisy_req(REQ_TICK);
    r.route_ready = route;
    send_item(r);
  endtask

  task automatic send_ack(logic [15:0] num, logic ok);
    sbs_req_t r;
    r = noisy_req(REQ_ACK);
    r.ack_number  = num;
    r.ack_size_ok = ok;
    send_item(r);
  endtask

  task automatic send_write(logic [11:0] addr, logic [7:0] data);
    sbs_req_t r;
    r = noisy_req(REQ_WRITE);
    r.image_address = addr;
    r.image_byte    = data;
    send_item(r);
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    start_i     = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_NODE_ID:   node_id_reg = data;
      CFG_IMAGE_LEN: img_len_reg = data[12:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drop start, wait for all pending bytes, then let the block settle
  task automatic drain_results();
    int waited;
    @(negedge clk_i);
    start_i = 1'b0;
    waited  = 0;
    while (packet_bytes_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (packet_bytes_q.size() != 0) begin
      $display("%0t ns: %0d packet bytes expected, got none", $time, packet_bytes_q.size());
      errors++;
      packet_bytes_q.delete();
    end
    while (busy_o !== 1'b0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Fill the start of the store back to back; ticks below read only written bytes
  task automatic test_image_preload();
    steady_send = 1'b1;
    for (int a = 0; a < PRELOAD_BYTES; a++) send_write(12'(a), 8'($urandom));
    steady_send = 1'b0;
    drain_results();
  endtask

  task automatic test_dropped_requests();
    // node identity still at its reset value
    send_tick(1'b1);
    send_item(noisy_req(REQ_NONE));
    send_ack(END_MARK, 1'b0);
    send_ack(16'd0, 1'b0);
    drain_results();
    write_reg(CFG_NODE_ID, 16'hFFFF);
    send_tick(1'b1);
    drain_results();
    write_reg(CFG_NODE_ID, SENDER_ID);
    send_tick(1'b0);
    send_item(noisy_req(REQ_NONE));
    drain_results();
  endtask

  // Walk a two-block image: resend, stale ack, advance, end packet, restart
  task automatic test_block_sequence();
    write_reg(CFG_IMAGE_LEN, 16'(PRELOAD_BYTES));
    send_tick(1'b1);
    send_tick(1'b1);
    send_write(12'd5, 8'hA5);
    send_tick(1'b1);
    send_ack(16'd1, 1'b1);
    send_ack(16'd0, 1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_ack(16'd1, 1'b1);
    send_tick(1'b1);
    send_ack(16'd2, 1'b1);
    send_tick(1'b1);
    send_ack(RESTART_MARK, 1'b1);
    send_tick(1'b1);
    drain_results();
  endtask

  task automatic test_length_extremes();
    // empty image: only the end packet
    write_reg(CFG_IMAGE_LEN, 16'd0);
    send_tick(1'b1);
    drain_results();
    write_reg(CFG_IMAGE_LEN, 16'd1);
    send_ack(RESTART_MARK, 1'b1);
    send_tick(1'b1);
    send_ack(16'd0, 1'b1);
    send_tick(1'b1);
    drain_results();
    // exactly one full block
    write_reg(CFG_IMAGE_LEN, 16'(BLOCK_BYTES));
    send_ack(RESTART_MARK, 1'b1);
    send_tick(1'b1);
    send_ack(16'd0, 1'b1);
    send_tick(1'b1);
    drain_results();
    // length past the store clamps to the full image
    write_reg(CFG_IMAGE_LEN, 16'hFFFF);
    send_ack(RESTART_MARK, 1'b1);
    send_tick(1'b1);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int          len, pick, sel;
    logic [15:0] num;
    for (int ph = 0; ph < 4; ph++) begin
      steady_send = (ph == 0);
      // Pick settings; images mostly stay within the written part of the store
      case ($urandom_range(9))
        0:       len = 0;
        1:       len = $urandom_range(IMAGE_BYTES_DEF + 1, 8191);
        default: len = $urandom_range(1, PRELOAD_BYTES);
      endcase
      write_reg(CFG_IMAGE_LEN, {3'($urandom), 13'(len)});
      write_reg(CFG_NODE_ID, ($urandom_range(9) == 0) ? 16'($urandom) : SENDER_ID);
      send_ack(RESTART_MARK, 1'b1);
      // Mostly well-formed tick and ack traffic, with noise mixed in
      repeat (8) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          send_tick(($urandom_range(9) != 0) && tick_reads_written());
        end else if (pick < 75) begin
          sel = $urandom_range(9);
          if (sel < 7) begin
            send_ack(blk_next, 1'b1);
          end else if (sel == 7) begin
            send_ack(RESTART_MARK, 1'b1);
          end else if (sel == 8) begin
            num = 16'($urandom);
            if (num == END_MARK) num = RESTART_MARK;
            send_ack(num, 1'b1);
          end else begin
            send_ack(16'($urandom), 1'b0);
          end
        end else if (pick < 95) begin
          send_write(12'($urandom_range(0, PRELOAD_BYTES + 31)), 8'($urandom));
        end else begin
          send_item(noisy_req(REQ_NONE));
        end
      end
      drain_results();
    end
    steady_send = 1'b0;
  endtask

  // The end mark is sticky, so this runs last
  task automatic test_transfer_end();
    write_reg(CFG_NODE_ID, SENDER_ID);
    write_reg(CFG_IMAGE_LEN, 16'd200);
    send_ack(END_MARK, 1'b1);
    send_tick(1'b1);
    send_ack(RESTART_MARK, 1'b1);
    send_tick(1'b1);
    send_write(12'hFFF, 8'hFF);
    send_tick(1'b1);
    drain_results();
  endtask

  initial begin
    start_i     = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    errors      = 0;
    cycle_count = 0;
    steady_send = 1'b0;
    blk_next    = '0;
    blk_acked   = 1'b1;
    xfer_done   = 1'b0;
    node_id_reg = '0;
    img_len_reg = 13'(IMAGE_BYTES_DEF);
    pkt_block   = '0;
    pkt_len     = '0;
    pkt_sum     = '0;
    foreach (pkt_data[i]) pkt_data[i] = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_image_preload();
    test_dropped_requests();
    test_block_sequence();
    test_length_extremes();
    test_random_traffic();
    test_transfer_end();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
